// ===== rtl/core/bts_pkg.sv =====
// Shared types and constants for the bilinear texture sampler.
// No dependencies.
package bts_pkg;

  localparam int MAX_DIM_DEF   = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIM_W         = 9;
  localparam int ADDR_W        = 16;
  localparam int TEXEL_W       = 24;
  localparam int COORD_W       = 18;
  localparam int OUT_W         = 16;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

// ===== rtl/core/bts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bts_axis.sv =====
// Per-axis corner and fraction computation: clamp, scale, edge fixups.
// Depends on bts_pkg. Purely combinational; caller registers the outputs.
module bts_axis #(
  parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF,
  parameter int MAX_DIM   = bts_pkg::MAX_DIM_DEF,
  parameter int CW        = FRAC_BITS + 2,
  parameter int PW        = $clog2(MAX_DIM)
) (
  input  logic [CW-1:0]      coord,
  input  logic [PW:0]        dim,
  output logic [PW-1:0]      lo,
  output logic [PW-1:0]      hi,
  output logic [FRAC_BITS:0] frac
);

  localparam int ONE  = 1 << FRAC_BITS;
  localparam int PRW  = FRAC_BITS + 1 + PW + 1;

  logic [FRAC_BITS:0] c;
  logic [PRW-1:0]     p;
  logic [PRW-FRAC_BITS-1:0] b, e, dm1;
  logic [PRW-1:0]     f;

  always_comb begin
    if (coord[CW-1]) begin
      c = '0;
    end else if (coord[CW-2:0] > (CW-1)'(ONE)) begin
      c = (FRAC_BITS+1)'(ONE);
    end else begin
      c = coord[FRAC_BITS:0];
    end
    p   = PRW'(c) * PRW'(dim);
    b   = p[PRW-1:FRAC_BITS];
    e   = b + ((p[FRAC_BITS-1:0] != '0) ? 1'b1 : 1'b0);
    dm1 = (PRW-FRAC_BITS)'(dim) - 1'b1;
    if (b >= dm1) begin
      b = dm1 - 1'b1;
      e = dm1;
    end
    if (e == '0) begin
      b = '0;
      e = (PRW-FRAC_BITS)'(1);
    end
    f = p - {b, {FRAC_BITS{1'b0}}};
    if (f > PRW'(ONE)) begin
      f = PRW'(ONE);
    end
    lo   = b[PW-1:0];
    hi   = e[PW-1:0];
    frac = f[FRAC_BITS:0];
  end

endmodule

// ===== rtl/core/bts_blend.sv =====
// One channel of the bilinear blend, three register stages:
// weight-by-texel products, pair sums, final sum and rounding.
// Depends on bts_pkg.
module bts_blend #(
  parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*FRAC_BITS:0]      w00,
  input  logic [2*FRAC_BITS:0]      w10,
  input  logic [2*FRAC_BITS:0]      w11,
  input  logic [2*FRAC_BITS:0]      w01,
  input  logic [7:0]                a,
  input  logic [7:0]                b,
  input  logic [7:0]                c,
  input  logic [7:0]                d,
  output logic [bts_pkg::OUT_W-1:0] res
);

  localparam int PW = 2*FRAC_BITS + 9;
  localparam int SW = PW + 2;

  logic [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic [PW:0]   s0_r, s1_r;
  logic [bts_pkg::OUT_W-1:0] res_r;
  logic [SW-1:0] sum;

  always_comb begin
    sum = SW'(s0_r) + SW'(s1_r) + (SW'(1) << (2*FRAC_BITS - 9));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= PW'(w00) * PW'(a);
      pb_r  <= PW'(w10) * PW'(b);
      pc_r  <= PW'(w11) * PW'(c);
      pd_r  <= PW'(w01) * PW'(d);
      s0_r  <= (PW+1)'(pa_r) + (PW+1)'(pb_r);
      s1_r  <= (PW+1)'(pc_r) + (PW+1)'(pd_r);
      res_r <= sum[2*FRAC_BITS-8 +: bts_pkg::OUT_W];
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/core/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler.
// Depends on bts_pkg, bts_ram, bts_axis and bts_blend.
//
// Pipelined bilinear texture unit: one request per cycle, write or sample, while
// the output is not stalled. Write requests store an RGB texel in four replicated
// 64K x 24 stores (one per corner) and produce no result. A write travels two
// stages before it lands, so it reaches the stores at the same point where
// samples read them, and every sample sees exactly the writes that came before
// it. Sample requests flow through seven stages: coordinate clamp/scale and
// corner selection, address multiply, four parallel texel reads (registered RAM
// output) alongside the fraction weight products, three-stage per-channel blend
// (products, pair sums, rounding), then the output register. A single global
// enable advances the whole pipe whenever the output slot is empty or being
// taken, so stalls drop or repeat nothing. Texels never written read as
// undefined. Dimension registers below 2 act as 2 and above MAX_DIM act as
// MAX_DIM.
module bilinear_texture_sampler #(
  parameter int MAX_DIM   = bts_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [bts_pkg::ADDR_W-1:0]  in_texel_index,
  input  logic [7:0]                  in_red_in,
  input  logic [7:0]                  in_green_in,
  input  logic [7:0]                  in_blue_in,
  input  logic signed [FRAC_BITS+1:0] in_u_coord,
  input  logic signed [FRAC_BITS+1:0] in_v_coord,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bts_pkg::OUT_W-1:0]   out_red_out,
  output logic [bts_pkg::OUT_W-1:0]   out_green_out,
  output logic [bts_pkg::OUT_W-1:0]   out_blue_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [bts_pkg::DIM_W-1:0]   cfg_data
);

  localparam int PW    = $clog2(MAX_DIM);
  localparam int AW    = bts_pkg::ADDR_W;
  localparam int WW    = 2*FRAC_BITS + 1;
  localparam int NST   = 7;
  localparam int ONE   = 1 << FRAC_BITS;

  // Dimension registers
  logic [bts_pkg::DIM_W-1:0] width_r, height_r;
  logic [PW:0] w_eff, h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bts_pkg::DIM_W'(256);
      height_r <= bts_pkg::DIM_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (bts_pkg::reg_idx_t'(cfg_index))
        bts_pkg::REG_WIDTH:  width_r  <= cfg_data;
        bts_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [PW:0] eff_dim(input logic [bts_pkg::DIM_W-1:0] r);
    logic [31:0] v;
    v = 32'(r);
    if (v < 32'd2) begin
      return (PW+1)'(2);
    end else if (v > 32'(MAX_DIM)) begin
      return (PW+1)'(MAX_DIM);
    end
    return (PW+1)'(v);
  endfunction

  assign w_eff = eff_dim(width_r);
  assign h_eff = eff_dim(height_r);

  // Global advance: move when the output slot is free or being drained
  logic adv;
  logic [NST-1:0] vld_r;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[NST-1];

  logic acc, is_wr, is_smp;
  assign acc    = in_valid && in_ready;
  assign is_wr  = acc && (bts_pkg::op_t'(in_op) == bts_pkg::OP_WRITE);
  assign is_smp = acc && (bts_pkg::op_t'(in_op) == bts_pkg::OP_SAMPLE);

  // Write requests ride two stages so they land where samples read
  logic wr1_r, wr2_r;
  logic [AW-1:0] widx1_r, widx2_r;
  logic [bts_pkg::TEXEL_W-1:0] wd1_r, wd2_r;
  logic wr_en;
  assign wr_en = wr2_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      wr1_r <= 1'b0;
      wr2_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], is_smp};
      wr1_r <= is_wr;
      wr2_r <= wr1_r;
    end
  end

  // Stage 1: corners and fractions
  logic [PW-1:0] x0, x1, y0, y1;
  logic [FRAC_BITS:0] s, t;

  bts_axis #(.FRAC_BITS(FRAC_BITS), .MAX_DIM(MAX_DIM)) u_ax (
    .coord(in_u_coord), .dim(w_eff), .lo(x0), .hi(x1), .frac(s));
  bts_axis #(.FRAC_BITS(FRAC_BITS), .MAX_DIM(MAX_DIM)) u_ay (
    .coord(in_v_coord), .dim(h_eff), .lo(y0), .hi(y1), .frac(t));

  logic [PW-1:0] x0_r, x1_r, y0_r, y1_r;
  logic [FRAC_BITS:0] s1_r, t1_r, s2_r, t2_r;
  logic [PW:0] w1_r;

  // Stage 2: row base addresses
  logic [AW-1:0] rb0_r, rb1_r, x0b_r, x1b_r;

  // Stage 3: weights (product of the fractions), in parallel with the RAM read
  logic [WW-1:0] w00_r, w10_r, w11_r, w01_r;
  logic [FRAC_BITS:0] ws, wt;
  assign ws = (FRAC_BITS+1)'(ONE) - s2_r;
  assign wt = (FRAC_BITS+1)'(ONE) - t2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r    <= x0;
      x1_r    <= x1;
      y0_r    <= y0;
      y1_r    <= y1;
      s1_r    <= s;
      t1_r    <= t;
      w1_r    <= w_eff;
      widx1_r <= in_texel_index;
      wd1_r   <= {in_red_in, in_green_in, in_blue_in};
      widx2_r <= widx1_r;
      wd2_r   <= wd1_r;
      rb0_r   <= AW'(32'(y0_r) * 32'(w1_r));
      rb1_r   <= AW'(32'(y1_r) * 32'(w1_r));
      x0b_r   <= AW'(x0_r);
      x1b_r   <= AW'(x1_r);
      s2_r    <= s1_r;
      t2_r    <= t1_r;
      w00_r   <= WW'(ws) * WW'(wt);
      w10_r   <= WW'(s2_r) * WW'(wt);
      w11_r   <= WW'(s2_r) * WW'(t2_r);
      w01_r   <= WW'(ws) * WW'(t2_r);
    end
  end

  // Stage 2 addresses, read data registered in stage 3
  logic [AW-1:0] a00, a10, a11, a01;
  assign a00 = rb0_r + x0b_r;
  assign a10 = rb0_r + x1b_r;
  assign a11 = rb1_r + x1b_r;
  assign a01 = rb1_r + x0b_r;

  logic [bts_pkg::TEXEL_W-1:0] wdata;
  logic [bts_pkg::TEXEL_W-1:0] q00, q10, q11, q01;
  assign wdata = wd2_r;

  bts_ram #(.WIDTH(bts_pkg::TEXEL_W), .DEPTH(1 << AW)) u_m00 (
    .clk, .we(wr_en), .waddr(widx2_r), .wdata, .re(adv), .raddr(a00), .rdata(q00));
  bts_ram #(.WIDTH(bts_pkg::TEXEL_W), .DEPTH(1 << AW)) u_m10 (
    .clk, .we(wr_en), .waddr(widx2_r), .wdata, .re(adv), .raddr(a10), .rdata(q10));
  bts_ram #(.WIDTH(bts_pkg::TEXEL_W), .DEPTH(1 << AW)) u_m11 (
    .clk, .we(wr_en), .waddr(widx2_r), .wdata, .re(adv), .raddr(a11), .rdata(q11));
  bts_ram #(.WIDTH(bts_pkg::TEXEL_W), .DEPTH(1 << AW)) u_m01 (
    .clk, .we(wr_en), .waddr(widx2_r), .wdata, .re(adv), .raddr(a01), .rdata(q01));

  // Stages 4..6: per-channel blend, red at the top of the texel word
  logic [bts_pkg::OUT_W-1:0] rr, gg, bb;

  bts_blend #(.FRAC_BITS(FRAC_BITS)) u_br (
    .clk, .en(adv), .w00(w00_r), .w10(w10_r), .w11(w11_r), .w01(w01_r),
    .a(q00[23:16]), .b(q10[23:16]), .c(q11[23:16]), .d(q01[23:16]), .res(rr));
  bts_blend #(.FRAC_BITS(FRAC_BITS)) u_bg (
    .clk, .en(adv), .w00(w00_r), .w10(w10_r), .w11(w11_r), .w01(w01_r),
    .a(q00[15:8]), .b(q10[15:8]), .c(q11[15:8]), .d(q01[15:8]), .res(gg));
  bts_blend #(.FRAC_BITS(FRAC_BITS)) u_bb (
    .clk, .en(adv), .w00(w00_r), .w10(w10_r), .w11(w11_r), .w01(w01_r),
    .a(q00[7:0]), .b(q10[7:0]), .c(q11[7:0]), .d(q01[7:0]), .res(bb));

  // Stage 7: output register
  logic [bts_pkg::OUT_W-1:0] ro_r, go_r, bo_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ro_r <= rr;
      go_r <= gg;
      bo_r <= bb;
    end
  end

  assign out_red_out   = ro_r;
  assign out_green_out = go_r;
  assign out_blue_out  = bo_r;

  // Hold the whole pipe while a result waits at the output.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(vld_r) && $stable(out_red_out))
    else $error("pipe moved during output stall");
  // Never take a request while a result is blocked.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken during stall");
  // A write request never produces a result.
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_op |=> !vld_r[0])
    else $error("write request created a result");

endmodule
